/* design/bsfc_pkg.sv */
// Shared types and constants for the byte-stuffing framer with checksum trailer.
`default_nettype none
package bsfc_pkg;

	localparam int ByteW      = 8;
	localparam int QueueDepth = 4;

	// Configuration register indexes, byte address 4*index
	localparam int AddrW = 3;
	localparam logic [0:0] RegFlag   = 1'b0;
	localparam logic [0:0] RegEscape = 1'b1;

	localparam logic [ByteW-1:0] FlagReset   = 8'd36;
	localparam logic [ByteW-1:0] EscapeReset = 8'd47;

	// One classified input item, as handed from front to back
	typedef struct packed {
		logic             open;
		logic             esc;
		logic             last;
		logic [ByteW-1:0] data;
		logic [ByteW-1:0] flag;
		logic [ByteW-1:0] escape;
	} cmd_t;

endpackage
`default_nettype wire

/* design/bsfc_front.sv */
// Front end: accepts payload bytes and classifies them into framing commands.
`default_nettype none
module bsfc_front
	import bsfc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [ByteW-1:0] data_byte,
	input  wire logic             last_byte,
	input  wire logic [ByteW-1:0] flag_value,
	input  wire logic [ByteW-1:0] escape_value,
	input  wire logic             q_full,
	output cmd_t                  q_wdata,
	output logic                  q_push
);

	logic in_frame_q;

	assign q_push = push && !q_full;

	always_comb begin
		q_wdata.open   = !in_frame_q;
		q_wdata.esc    = (data_byte == flag_value) || (data_byte == escape_value);
		q_wdata.last   = last_byte;
		q_wdata.data   = data_byte;
		q_wdata.flag   = flag_value;
		q_wdata.escape = escape_value;
	end

	// frame opens on the first byte, closes after the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
		end else if (q_push) begin
			in_frame_q <= !last_byte;
		end
	end

endmodule
`default_nettype wire

/* design/bsfc_queue.sv */
// Short command queue between the front end and the emitter.
`default_nettype none
module bsfc_queue
	import bsfc_pkg::*;
#(
	parameter int Depth = QueueDepth
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wdata,
	output logic      full,
	input  wire logic pop,
	output cmd_t      rdata,
	output logic      empty
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	cmd_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = (count_q == FullCnt);
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* design/bsfc_back.sv */
// Back end: steps through each command, emits framed bytes, keeps the checksum.
`default_nettype none
module bsfc_back
	import bsfc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmd_t             q_rdata,
	input  wire logic             q_empty,
	output logic                  q_pop,
	output logic                  empty,
	input  wire logic             pop,
	output logic [ByteW-1:0]      out_byte,
	output logic                  is_trailer,
	output logic                  run_end
);

	typedef enum logic [2:0] {
		STEP_OPEN, STEP_ESC, STEP_DATA, STEP_CLOSE, STEP_TRAILER
	} step_t;

	cmd_t            cmd_q;
	logic            busy_q;
	logic [4:0]      pend_q;
	logic [ByteW-1:0] sum_q;

	logic            out_valid_q;
	logic [ByteW-1:0] out_byte_q;
	logic            is_trailer_q;
	logic            run_end_q;

	step_t            step;
	logic [4:0]       pend_next;
	logic [ByteW-1:0] emit_byte;
	logic [ByteW:0]   sum_wide;
	logic [ByteW-1:0] sum_next;
	logic             advance;
	logic             done;

	assign empty      = !out_valid_q;
	assign out_byte   = out_byte_q;
	assign is_trailer = is_trailer_q;
	assign run_end    = run_end_q;

	always_comb begin
		if (pend_q[0]) begin
			step = STEP_OPEN;
		end else if (pend_q[1]) begin
			step = STEP_ESC;
		end else if (pend_q[2]) begin
			step = STEP_DATA;
		end else if (pend_q[3]) begin
			step = STEP_CLOSE;
		end else begin
			step = STEP_TRAILER;
		end
	end

	always_comb begin
		unique case (step)
			STEP_OPEN:    emit_byte = cmd_q.flag;
			STEP_ESC:     emit_byte = cmd_q.escape;
			STEP_DATA:    emit_byte = cmd_q.data;
			STEP_CLOSE:   emit_byte = cmd_q.flag;
			STEP_TRAILER: emit_byte = ~sum_q;
			default:      emit_byte = cmd_q.data;
		endcase
	end

	// end-around-carry add
	assign sum_wide = {1'b0, sum_q} + {1'b0, emit_byte};
	assign sum_next = sum_wide[ByteW-1:0] + {{(ByteW-1){1'b0}}, sum_wide[ByteW]};

	assign pend_next = pend_q & ~(5'b00001 << step);
	assign advance   = busy_q && (!out_valid_q || pop);
	assign done      = advance && (pend_next == '0);
	assign q_pop     = !q_empty && (!busy_q || done);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_rdata;
		end
		if (advance) begin
			out_byte_q   <= emit_byte;
			is_trailer_q <= (step == STEP_TRAILER);
			run_end_q    <= (pend_next == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pend_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				sum_q       <= (step == STEP_TRAILER) ? '0 : sum_next;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				busy_q <= 1'b1;
				pend_q <= {q_rdata.last, q_rdata.last, 1'b1, q_rdata.esc, q_rdata.open};
			end else if (advance) begin
				busy_q <= !done;
				pend_q <= pend_next;
			end
		end
	end

endmodule
`default_nettype wire

/* design/byte_stuff_framer_checksum_core.sv */
// Top level of the byte-stuffing framer with ones' complement checksum trailer.
//
//  channel   direction  handshake               payload
//  -------   ---------  ---------               -------
//  input     in         push / full             data_byte, last_byte
//  result    out        empty / pop             out_byte, is_trailer, run_end
//  config    in         APB psel/penable/pwrite paddr (0 flag, 4 escape), pwdata
//
// Each accepted byte turns into 1 to 5 result transactions (opening flag,
// escape, byte, closing flag, trailer), typically 1 or 2; the emitter
// produces one per cycle while the result side keeps popping.
// The front end accepts one byte per cycle into a QDepth-entry command queue;
// full rises only when that queue fills behind a stalled or busy emitter.
// A single output register holds the oldest result; it reloads in the same
// cycle it is popped, so pop held high drains at full rate.
// Reset: flag 36, escape 47, no frame open, checksum zero, queue empty.
`default_nettype none
module byte_stuff_framer_checksum_core
	import bsfc_pkg::*;
#(
	parameter int QDepth = QueueDepth
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// payload in
	input  wire logic             push,
	output logic                  full,
	input  wire logic [ByteW-1:0] data_byte,
	input  wire logic             last_byte,
	// results out
	output logic                  empty,
	input  wire logic             pop,
	output logic [ByteW-1:0]      out_byte,
	output logic                  is_trailer,
	output logic                  run_end,
	// config
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [AddrW-1:0] paddr,
	input  wire logic [31:0]      pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic [ByteW-1:0] flag_q;
	logic [ByteW-1:0] escape_q;
	logic [0:0]       reg_idx;
	logic             cfg_wr;

	cmd_t q_wdata;
	cmd_t q_rdata;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;

	// config registers, one word each
	assign pready  = 1'b1;
	assign reg_idx = paddr[2:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			RegFlag:   prdata = {24'd0, flag_q};
			RegEscape: prdata = {24'd0, escape_q};
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q   <= FlagReset;
			escape_q <= EscapeReset;
		end else if (cfg_wr) begin
			if (reg_idx == RegFlag) begin
				flag_q <= pwdata[ByteW-1:0];
			end else begin
				escape_q <= pwdata[ByteW-1:0];
			end
		end
	end

	assign full = q_full;

	// classify: opening flag needed, escape needed, closing needed
	bsfc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.flag_value   (flag_q),
		.escape_value (escape_q),
		.q_full       (q_full),
		.q_wdata      (q_wdata),
		.q_push       (q_push)
	);

	bsfc_queue #(
		.Depth (QDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// emitter: one framed byte per cycle unless results back up, running checksum
	bsfc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_rdata    (q_rdata),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.is_trailer (is_trailer),
		.run_end    (run_end)
	);

	// trailer always closes the run of results for its item
	a_trailer_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && is_trailer) |-> run_end)
		else $error("trailer without run_end");

	// emitter never pulls from an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command queue underflow");

	// front never writes a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (!q_full && push))
		else $error("command queue overflow");

endmodule
`default_nettype wire

/* dv/byte_stuff_framer_checksum_core_tb.sv */
// Self-checking testbench for the byte-stuffing framer with checksum trailer.
`timescale 1ns / 100ps
module byte_stuff_framer_checksum_core_tb;
	import bsfc_pkg::*;

	localparam int HalfPeriod = 6;
	localparam int ResetCycles = 8;
	// Receiver hold-off long enough to fill the command queue and raise full.
	localparam int HoldOffCycles = 300;
	localparam int HoldOffAfterItems = 80;
	// Idle-cycle budget: hold-off plus the longest random gap, with margin.
	localparam int StallLimit = 2000;
	localparam int TailCycles = 20;
	localparam int RandomItemsPerPhase = 42;

	// One byte of the framed stream as it should leave the block.
	typedef struct packed {
		logic [ByteW-1:0] value;
		logic             trailer;
		logic             ends_item;
	} framed_byte_t;

	// Framer model: stuffing, flags and end-around-carry checksum, plus the
	// queue of framed bytes still owed by the block.
	class framer_model;
		logic [ByteW-1:0] flag_val;
		logic [ByteW-1:0] esc_val;
		bit               in_frame;
		logic [ByteW-1:0] frame_sum;
		framed_byte_t     bytes_due[$];
		int               payload_count;
		int               mismatches;

		function new();
			flag_val      = FlagReset;
			esc_val       = EscapeReset;
			in_frame      = 1'b0;
			frame_sum     = '0;
			payload_count = 0;
			mismatches    = 0;
		endfunction

		function void set_reg(logic [0:0] idx, logic [ByteW-1:0] v);
			if (idx == RegFlag) begin
				flag_val = v;
			end else begin
				esc_val = v;
			end
		endfunction

		function int due_count();
			return bytes_due.size();
		endfunction

		// Append one owed byte at the tail of the queue.
		function void add_due(logic [ByteW-1:0] v, logic tr);
			framed_byte_t fb;
			fb.value     = v;
			fb.trailer   = tr;
			fb.ends_item = 1'b0;
			bytes_due.insert(bytes_due.size(), fb);
		endfunction

		// Emit one frame byte and fold it into the sum, carry wrapping to bit 0.
		function void emit_summed(logic [ByteW-1:0] b);
			logic [ByteW:0] s;
			s = {1'b0, frame_sum} + {1'b0, b};
			frame_sum = s[ByteW-1:0] + {{(ByteW-1){1'b0}}, s[ByteW]};
			add_due(b, 1'b0);
		endfunction

		function void note_payload(logic [ByteW-1:0] d, logic l);
			payload_count++;
			if (!in_frame) begin
				emit_summed(flag_val);
				in_frame = 1'b1;
			end
			// flag == escape still gets just one escape
			if (d == flag_val || d == esc_val) begin
				emit_summed(esc_val);
			end
			emit_summed(d);
			if (l) begin
				emit_summed(flag_val);
				add_due(~frame_sum, 1'b1);
				frame_sum = '0;
				in_frame  = 1'b0;
			end
			bytes_due[bytes_due.size()-1].ends_item = 1'b1;
		endfunction

		task report_mismatch(string what);
			$display("[%0t] MISMATCH: %s", $realtime, what);
			mismatches++;
		endtask

		task check_out_byte(logic [ByteW-1:0] ob, logic tr, logic re);
			framed_byte_t want;
			if (bytes_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result byte %02h", ob));
				return;
			end
			want = bytes_due.pop_front();
			if (ob !== want.value) begin
				report_mismatch($sformatf("out_byte %02h, want %02h", ob, want.value));
			end
			if (tr !== want.trailer) begin
				report_mismatch($sformatf("is_trailer %b, want %b (byte %02h)",
					tr, want.trailer, want.value));
			end
			if (re !== want.ends_item) begin
				report_mismatch($sformatf("run_end %b, want %b (byte %02h)",
					re, want.ends_item, want.value));
			end
		endtask
	endclass

	// Clock, reset and every DUT input start at a known value.
	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             push      = 1'b0;
	logic [ByteW-1:0] data_byte = '0;
	logic             last_byte = 1'b0;
	logic             pop       = 1'b0;
	logic             psel      = 1'b0;
	logic             penable   = 1'b0;
	logic             pwrite    = 1'b0;
	logic [AddrW-1:0] paddr     = '0;
	logic [31:0]      pwdata    = '0;

	logic             full;
	logic             empty;
	logic [ByteW-1:0] out_byte;
	logic             is_trailer;
	logic             run_end;
	logic [31:0]      prdata;
	logic             pready;

	framer_model pred;
	bit          no_idle = 1'b0;
	int          stalled_cycles = 0;

	always #HalfPeriod clk = ~clk;

	byte_stuff_framer_checksum_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.is_trailer (is_trailer),
		.run_end    (run_end),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// Mostly short gaps, now and then a long one; none in burst phases.
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 45) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	// Offer one payload byte. push is left high after the transaction so a
	// back-to-back item does not drop and re-raise it in the same step.
	task automatic send_payload(input logic [ByteW-1:0] d, input logic l);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push      <= 1'b1;
		data_byte <= d;
		last_byte <= l;
		do @(posedge clk); while (full !== 1'b0);
		pred.note_payload(d, l);
	endtask

	// Result side: random pops, plus one long hold-off mid-run so the
	// command queue backs up and full has to assert.
	task automatic drain_results();
		int gap;
		bit held;
		held = 1'b0;
		forever begin
			if (!held && pred.payload_count >= HoldOffAfterItems) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (HoldOffCycles) @(posedge clk);
			end
			gap = idle_cycles();
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty !== 1'b0);
			pred.check_out_byte(out_byte, is_trailer, run_end);
		end
	endtask

	// APB write: setup then access; the register takes the value at the
	// edge where psel, penable, pwrite and pready are all high.
	task automatic apb_write(input logic [0:0] idx, input logic [ByteW-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {{(32-ByteW){1'b0}}, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		pred.set_reg(idx, v);
	endtask

	// Stop offering and wait for every owed result. Every payload byte causes
	// at least one result, so the block is idle once the queue is empty.
	task automatic settle();
		push <= 1'b0;
		while (pred.due_count() != 0) @(posedge clk);
	endtask

	task automatic reconfigure(input logic [ByteW-1:0] f, input logic [ByteW-1:0] e);
		apb_write(RegFlag, f);
		apb_write(RegEscape, e);
	endtask

	// Random frames: payload biased toward flag/escape hits, frames of
	// varied length ending about one byte in four.
	task automatic random_frames(input int n);
		int               r;
		logic [ByteW-1:0] d;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 20) begin
				d = pred.flag_val;
			end else if (r < 35) begin
				d = pred.esc_val;
			end else begin
				d = ByteW'($urandom_range(0, 255));
			end
			send_payload(d, ($urandom_range(0, 3) == 0));
		end
		settle();
	endtask

	// Watchdog: any cycle with no transaction on any port counts toward
	// the limit; a hung block ends the run here.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (psel && penable)) begin
			stalled_cycles <= 0;
		end else if (stalled_cycles >= StallLimit) begin
			$display("[%0t] watchdog: no transaction for %0d cycles", $realtime, StallLimit);
			$display("Some tests failed");
			$finish;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [ByteW-1:0] rand_flag;
		logic [ByteW-1:0] rand_esc;
		pred = new();
		fork
			drain_results();
		join_none
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset register values ('$' flag, '/' escape).
		// Single-byte frames: flag and escape payload give all five results.
		send_payload(FlagReset, 1'b1);
		send_payload(EscapeReset, 1'b1);
		send_payload(8'h00, 1'b1);
		send_payload(8'hFF, 1'b1);
		// Multi-byte frame mixing stuffed and plain bytes.
		send_payload(8'h55, 1'b0);
		send_payload(FlagReset, 1'b0);
		send_payload(EscapeReset, 1'b0);
		send_payload(8'hAA, 1'b0);
		send_payload(8'h00, 1'b1);
		// Run of 0xFF to drive the end-around carry every step.
		repeat (8) send_payload(8'hFF, 1'b0);
		send_payload(8'hFE, 1'b1);
		// Leave a frame open across the register change below.
		send_payload(FlagReset, 1'b0);
		send_payload(8'h11, 1'b0);
		settle();

		// Extremes; the open frame closes under the new values.
		reconfigure(8'h00, 8'hFF);
		send_payload(8'h00, 1'b0);
		send_payload(8'hFF, 1'b1);
		random_frames(RandomItemsPerPhase);

		reconfigure(8'hFF, 8'h00);
		random_frames(RandomItemsPerPhase);

		// Flag equal to escape: a match gets one escape only.
		reconfigure(8'h5A, 8'h5A);
		send_payload(8'h5A, 1'b1);
		random_frames(RandomItemsPerPhase);

		// Burst phase: no idling on either side.
		no_idle = 1'b1;
		reconfigure(8'h7E, 8'h7D);
		random_frames(RandomItemsPerPhase);
		no_idle = 1'b0;

		rand_flag = ByteW'($urandom_range(0, 255));
		rand_esc  = ByteW'($urandom_range(0, 255));
		reconfigure(rand_flag, rand_esc);
		random_frames(RandomItemsPerPhase);

		reconfigure(FlagReset, EscapeReset);
		random_frames(RandomItemsPerPhase);

		// Owed results are in; give any stray output time to show up.
		repeat (TailCycles) @(posedge clk);
		if (pred.mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* sim.f */
design/bsfc_pkg.sv
design/bsfc_front.sv
design/bsfc_queue.sv
design/bsfc_back.sv
design/byte_stuff_framer_checksum_core.sv
dv/byte_stuff_framer_checksum_core_tb.sv
